// ===== design/utf8_text_validator_assert.svh =====
// assertion macros for the utf8 text validator
`ifndef UTF8_TEXT_VALIDATOR_ASSERT_SVH
`define UTF8_TEXT_VALIDATOR_ASSERT_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define UTV_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("utf8 text validator check failed");

// condition must never be seen outside reset
`define UTV_NEVER(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("utf8 text validator forbidden condition");

`else

`define UTV_ASSERT(label, prop)
`define UTV_NEVER(label, cond)

`endif

`endif

// ===== design/utf8v_pkg.sv =====
// types and constants for the utf8 text validator
`default_nettype none

package utf8v_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned POINT_W = 21;
    localparam int unsigned TDATA_W = 24;
    localparam int unsigned TUSER_W = 2;

    localparam logic [POINT_W-1:0] MIN_TWO     = 21'h00080;
    localparam logic [POINT_W-1:0] MIN_THREE   = 21'h00800;
    localparam logic [POINT_W-1:0] MIN_FOUR    = 21'h10000;
    localparam logic [POINT_W-1:0] MAX_POINT   = 21'h10ffff;
    localparam logic [POINT_W-1:0] SURR_FIRST  = 21'h0d800;
    localparam logic [POINT_W-1:0] SURR_LAST   = 21'h0dfff;

    // length of the open sequence
    localparam logic [1:0] LEN_NONE  = 2'd0;
    localparam logic [1:0] LEN_TWO   = 2'd1;
    localparam logic [1:0] LEN_THREE = 2'd2;
    localparam logic [1:0] LEN_FOUR  = 2'd3;

    typedef struct packed {
        logic               still_valid;
        logic               string_done;
        logic [POINT_W-1:0] code_point;
        logic               point_ready;
    } utf8v_result_t;

endpackage

`default_nettype wire

// ===== design/utf8_text_validator.sv =====
// utf8 text validator top level
`default_nettype none

// Checks a byte stream as UTF-8 text, one byte per word, with tlast on the final byte of
// each string. Every accepted byte gives exactly one result word: tuser[0] is the verdict so
// far (on the tlast word, the final verdict), tuser[1] flags a completed code point whose
// scalar value sits in tdata[20:0], and tlast closes the string. Control bytes, bad lead
// bytes, stray or missing continuation bytes, overlong forms, surrogates and values above
// 0x10FFFF are rejected; an error holds until the end of the string and all state clears
// after the last byte. The block takes one byte every cycle while results are taken. The
// byte is held in an input register, decoded against the sequence state in one step, and
// the result is held in an output register, from which the result word is offered.

`include "utf8_text_validator_assert.svh"

module utf8_text_validator (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [utf8v_pkg::BYTE_W-1:0]  s_axis_tdata,  // text_byte
    input  wire logic                          s_axis_tlast,  // last_byte
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic [utf8v_pkg::TDATA_W-1:0]      m_axis_tdata,  // code_point, zero fill
    output logic [utf8v_pkg::TUSER_W-1:0]      m_axis_tuser,  // still_valid, point_ready
    output logic                               m_axis_tlast   // string_done
);

    logic                              in_valid_reg;
    logic [utf8v_pkg::BYTE_W-1:0]      in_byte_reg;
    logic                              in_last_reg;
    logic                              out_valid_reg;
    utf8v_pkg::utf8v_result_t          out_reg;
    utf8v_pkg::utf8v_result_t          out_next;

    logic                              error_seen_reg;
    logic                              error_seen_next;
    logic [1:0]                        pending_reg;
    logic [1:0]                        pending_next;
    logic [utf8v_pkg::POINT_W-1:0]     partial_reg;
    logic [utf8v_pkg::POINT_W-1:0]     partial_next;
    logic [1:0]                        length_reg;
    logic [1:0]                        length_next;

    logic                              advance;
    logic                              bad;
    logic                              ready;
    logic [utf8v_pkg::POINT_W-1:0]     point;
    logic [utf8v_pkg::POINT_W-1:0]     shifted;
    logic [utf8v_pkg::POINT_W-1:0]     lowest;
    logic                              value_ok;

    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || advance;

    assign shifted = {partial_reg[utf8v_pkg::POINT_W-7:0], in_byte_reg[5:0]};

    always_comb
    begin
        case (length_reg)
            utf8v_pkg::LEN_TWO:   lowest = utf8v_pkg::MIN_TWO;
            utf8v_pkg::LEN_THREE: lowest = utf8v_pkg::MIN_THREE;
            default:              lowest = utf8v_pkg::MIN_FOUR;
        endcase
        value_ok = (shifted >= lowest) && (shifted <= utf8v_pkg::MAX_POINT) &&
                   !((shifted >= utf8v_pkg::SURR_FIRST) && (shifted <= utf8v_pkg::SURR_LAST));
    end

    // decode one byte against the open sequence
    always_comb
    begin
        bad             = 1'b0;
        ready           = 1'b0;
        point           = '0;
        error_seen_next = error_seen_reg;
        pending_next    = pending_reg;
        partial_next    = partial_reg;
        length_next     = length_reg;

        if (!error_seen_reg)
        begin
            if (pending_reg == 2'd0)
            begin
                case (in_byte_reg) inside
                    [8'h20:8'h7e]:
                    begin
                        ready = 1'b1;
                        point = {13'd0, in_byte_reg};
                    end
                    [8'hc2:8'hdf]:
                    begin
                        pending_next = 2'd1;
                        partial_next = {16'd0, in_byte_reg[4:0]};
                        length_next  = utf8v_pkg::LEN_TWO;
                    end
                    [8'he0:8'hef]:
                    begin
                        pending_next = 2'd2;
                        partial_next = {17'd0, in_byte_reg[3:0]};
                        length_next  = utf8v_pkg::LEN_THREE;
                    end
                    [8'hf0:8'hf4]:
                    begin
                        pending_next = 2'd3;
                        partial_next = {18'd0, in_byte_reg[2:0]};
                        length_next  = utf8v_pkg::LEN_FOUR;
                    end
                    default:
                        bad = 1'b1;
                endcase
            end
            else if (in_byte_reg[7:6] != 2'b10)
            begin
                bad = 1'b1;
            end
            else
            begin
                partial_next = shifted;
                pending_next = pending_reg - 2'd1;
                if (pending_reg == 2'd1)
                begin
                    if (value_ok)
                    begin
                        ready = 1'b1;
                        point = shifted;
                    end
                    else
                    begin
                        bad = 1'b1;
                    end
                    partial_next = '0;
                    length_next  = utf8v_pkg::LEN_NONE;
                end
            end

            // string cut off inside a sequence
            if (!bad && in_last_reg && (pending_next != 2'd0))
                bad = 1'b1;

            if (bad)
            begin
                error_seen_next = 1'b1;
                pending_next    = 2'd0;
                partial_next    = '0;
                length_next     = utf8v_pkg::LEN_NONE;
                ready           = 1'b0;
                point           = '0;
            end
        end

        out_next.still_valid = !error_seen_next;
        out_next.string_done = in_last_reg;
        out_next.code_point  = point;
        out_next.point_ready = ready;

        if (in_last_reg)
        begin
            error_seen_next = 1'b0;
            pending_next    = 2'd0;
            partial_next    = '0;
            length_next     = utf8v_pkg::LEN_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            error_seen_reg <= 1'b0;
            pending_reg    <= 2'd0;
            partial_reg    <= '0;
            length_reg     <= utf8v_pkg::LEN_NONE;
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (advance)
                out_valid_reg <= in_valid_reg;
            if (advance && in_valid_reg)
            begin
                error_seen_reg <= error_seen_next;
                pending_reg    <= pending_next;
                partial_reg    <= partial_next;
                length_reg     <= length_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
        if (advance && in_valid_reg)
            out_reg <= out_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(utf8v_pkg::TDATA_W - utf8v_pkg::POINT_W){1'b0}}, out_reg.code_point};
    assign m_axis_tuser  = {out_reg.point_ready, out_reg.still_valid};
    assign m_axis_tlast  = out_reg.string_done;

    // a string end leaves the decoder clean
    `UTV_ASSERT(a_clear_after_last,
        (advance && in_valid_reg && in_last_reg) |=>
            (!error_seen_reg && (pending_reg == 2'd0) && (length_reg == utf8v_pkg::LEN_NONE)))

    // an error never leaves a sequence open
    `UTV_NEVER(a_error_no_pending, error_seen_reg && (pending_reg != 2'd0))

    // a reported code point is a valid scalar value and the verdict agrees
    `UTV_ASSERT(a_point_legal,
        (out_valid_reg && out_reg.point_ready) |->
            (out_reg.still_valid && (out_reg.code_point <= utf8v_pkg::MAX_POINT) &&
             !((out_reg.code_point >= utf8v_pkg::SURR_FIRST) &&
               (out_reg.code_point <= utf8v_pkg::SURR_LAST))))

endmodule

`default_nettype wire
